FILE: src/ddd_pkg.sv
// Shared types, constants and calendar functions for the date difference block.
`default_nettype none

package ddd_pkg;

   localparam int YEAR_BITS   = 14;
   localparam int WALK_YEAR_BITS = YEAR_BITS + 1;
   localparam int MONTH_BITS  = 4;
   localparam int DAY_BITS    = 5;
   localparam int COUNT_BITS  = 22;
   localparam int MONTHS      = 12;
   localparam int YEAR_MOD    = 400;
   localparam int CENTURY     = 100;
   localparam int MOD_BITS    = 9;

   // year mod 400 = 16 * ((year >> 4) mod 25) + (year & 15)
   localparam int YEAR_LO_BITS = 4;
   localparam int HI_BITS      = YEAR_BITS - YEAR_LO_BITS;
   localparam int YEAR_MOD_HI  = YEAR_MOD >> YEAR_LO_BITS;
   // floor(x * 41 / 1024) equals x / 25 for every x below 1024
   localparam int RECIP_25     = 41;
   localparam int RECIP_SHIFT  = 10;
   localparam int PROD_BITS    = HI_BITS + 6;
   localparam int QUOT_BITS    = PROD_BITS - RECIP_SHIFT;
   localparam int REM25_BITS   = MOD_BITS - YEAR_LO_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [DAY_BITS-1:0] MONTH_LEN [MONTHS] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'(MONTHS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_WALK,
      ST_DONE
   } st_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic check;
      logic walk_step;
      logic emit;
   } ddd_cmd_type;

   typedef struct packed {
      logic start_bad;
      logic walk_done;
   } ddd_sts_type;

   // leap test from the year modulo 400
   function automatic logic is_leap(input logic [MOD_BITS-1:0] r400);
      logic century;
      century = (r400 == MOD_BITS'(CENTURY)) || (r400 == MOD_BITS'(2 * CENTURY)) ||
                (r400 == MOD_BITS'(3 * CENTURY));
      return (r400[1:0] == 2'd0) && !century;
   endfunction

   function automatic logic [DAY_BITS-1:0] days_in_month(input logic [MONTH_BITS-1:0] month,
                                                         input logic leap);
      logic [DAY_BITS-1:0] len;
      case (month) inside
         MONTH_FEB:          len = leap ? 5'd29 : 5'd28;
         [4'd1:MONTH_DEC]:   len = MONTH_LEN[4'(month - 4'd1)];
         default:            len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: src/ddd_ctrl.sv
// Sequencer for the date difference block: year reduction, start check, day walk, result.
`default_nettype none

module ddd_ctrl
   import ddd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ddd_cmd_type      cmd,
   input  wire ddd_sts_type sts
);

   st_type state_ff, state_in;
   logic   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.start_bad ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (sts.walk_done) state_in = ST_DONE;
            else cmd.walk_step = 1'b1;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/ddd_datapath.sv
// Date registers, year-mod-400 reducer, day walker, step counter and result register.
`default_nettype none

module ddd_datapath
   import ddd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [YEAR_BITS-1:0]    req_start_year,
   input  wire logic [MONTH_BITS-1:0]   req_start_month,
   input  wire logic [DAY_BITS-1:0]     req_start_day,
   input  wire logic [YEAR_BITS-1:0]    req_end_year,
   input  wire logic [MONTH_BITS-1:0]   req_end_month,
   input  wire logic [DAY_BITS-1:0]     req_end_day,
   input  wire logic                    req_include_end_day,
   input  wire ddd_cmd_type             cmd,
   output ddd_sts_type                  sts,
   output logic [COUNT_BITS-1:0]        rsp_day_count,
   output logic                         rsp_bad_start_date
);

   logic [WALK_YEAR_BITS-1:0] year_ff, year_in;
   logic [MONTH_BITS-1:0]     month_ff, month_in;
   logic [DAY_BITS-1:0]       day_ff, day_in;
   logic [YEAR_BITS-1:0]      end_year_ff, end_year_in;
   logic [MONTH_BITS-1:0]     end_month_ff, end_month_in;
   logic [DAY_BITS-1:0]       end_day_ff, end_day_in;
   logic                      incl_ff, incl_in;
   logic [MOD_BITS-1:0]       r400_ff, r400_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      bad_ff, bad_in;
   logic [COUNT_BITS-1:0]     out_count_ff, out_count_in;
   logic                      out_bad_ff, out_bad_in;

   logic [HI_BITS-1:0]        year_hi;
   logic [PROD_BITS-1:0]      hi_prod;
   logic [QUOT_BITS-1:0]      hi_quot;
   logic [REM25_BITS-1:0]     hi_rem;
   logic                      leap;
   logic [DAY_BITS-1:0]       dim;
   logic                      start_bad;
   logic                      before_end;

   always_ff @(posedge clock) begin
      year_ff      <= year_in;
      month_ff     <= month_in;
      day_ff       <= day_in;
      end_year_ff  <= end_year_in;
      end_month_ff <= end_month_in;
      end_day_ff   <= end_day_in;
      incl_ff      <= incl_in;
      r400_ff      <= r400_in;
      count_ff     <= count_in;
      bad_ff       <= bad_in;
      out_count_ff <= out_count_in;
      out_bad_ff   <= out_bad_in;
   end

   // start year mod 400: upper bits mod 25 by reciprocal multiply, low nibble kept
   assign year_hi   = year_ff[YEAR_BITS-1:YEAR_LO_BITS];
   assign hi_prod   = PROD_BITS'(year_hi) * PROD_BITS'(RECIP_25);
   assign hi_quot   = hi_prod[PROD_BITS-1:RECIP_SHIFT];
   assign hi_rem    = REM25_BITS'(year_hi - HI_BITS'(hi_quot) * HI_BITS'(YEAR_MOD_HI));

   assign leap      = is_leap(r400_ff);
   assign dim       = days_in_month(month_ff, leap);
   assign start_bad = !(month_ff inside {[4'd1:MONTH_DEC]}) || (day_ff == '0) || (day_ff > dim);
   // lexicographic compare against the raw end fields
   assign before_end = {year_ff, month_ff, day_ff} <
                       {1'b0, end_year_ff, end_month_ff, end_day_ff};

   assign sts.start_bad = start_bad;
   assign sts.walk_done = !before_end || (count_ff == COUNT_MAX);

   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      end_year_in  = end_year_ff;
      end_month_in = end_month_ff;
      end_day_in   = end_day_ff;
      incl_in      = incl_ff;
      r400_in      = r400_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      out_count_in = out_count_ff;
      out_bad_in   = out_bad_ff;

      if (cmd.load) begin
         year_in      = {1'b0, req_start_year};
         month_in     = req_start_month;
         day_in       = req_start_day;
         end_year_in  = req_end_year;
         end_month_in = req_end_month;
         end_day_in   = req_end_day;
         incl_in      = req_include_end_day;
         r400_in      = '0;
         count_in     = '0;
         bad_in       = 1'b0;
      end

      if (cmd.mod_step) r400_in = {hi_rem, year_ff[YEAR_LO_BITS-1:0]};

      if (cmd.check) bad_in = start_bad;

      if (cmd.walk_step) begin
         count_in = count_ff + 1'b1;
         if (day_ff == dim) begin
            day_in = 5'd1;
            if (month_ff == MONTH_DEC) begin
               month_in = 4'd1;
               year_in  = year_ff + 1'b1;
               r400_in  = (r400_ff == MOD_BITS'(YEAR_MOD - 1)) ? '0 : r400_ff + 1'b1;
            end else begin
               month_in = month_ff + 1'b1;
            end
         end else begin
            day_in = day_ff + 1'b1;
         end
      end

      if (cmd.emit) begin
         out_bad_in = bad_ff;
         if (bad_ff)
            out_count_in = '0;
         else if (count_ff == COUNT_MAX)
            out_count_in = COUNT_MAX;
         else
            out_count_in = count_ff + COUNT_BITS'(incl_ff);
      end
   end

   assign rsp_day_count      = out_count_ff;
   assign rsp_bad_start_date = out_bad_ff;

endmodule

`default_nettype wire

FILE: src/date_difference_in_days.sv
// Top level: Gregorian date difference in days.
// Usage:
//   Request channel (req_valid / req_stall): start date, end date and the
//   include_end_day flag. A transaction is taken when req_valid is high and
//   req_stall is low; req_stall stays high while an item is in progress.
//   Response channel (rsp_valid / rsp_stall): day_count and bad_start_date,
//   one transaction per request, held in an output register.
// Timing:
//   The start year is reduced modulo 400, the start date is checked, then
//   the day walker advances one calendar day per cycle until the walk date
//   is no longer before the end date or the count saturates; rsp_valid
//   rises after the walk ends, and a bad start date skips the walk. One
//   item is in work at a time; the next request is taken only after the
//   previous one is done, so the walk length sets the rate.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
// If the receiver stalls, the response holds; the next request is still
// accepted and worked on, and its result waits until the register is free.
`default_nettype none

module date_difference_in_days
   import ddd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [YEAR_BITS-1:0]  req_start_year,
   input  wire logic [MONTH_BITS-1:0] req_start_month,
   input  wire logic [DAY_BITS-1:0]   req_start_day,
   input  wire logic [YEAR_BITS-1:0]  req_end_year,
   input  wire logic [MONTH_BITS-1:0] req_end_month,
   input  wire logic [DAY_BITS-1:0]   req_end_day,
   input  wire logic                  req_include_end_day,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COUNT_BITS-1:0]      rsp_day_count,
   output logic                       rsp_bad_start_date
);

   ddd_cmd_type cmd;
   ddd_sts_type sts;

   ddd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ddd_datapath u_datapath (
      .clock               (clock),
      .req_start_year      (req_start_year),
      .req_start_month     (req_start_month),
      .req_start_day       (req_start_day),
      .req_end_year        (req_end_year),
      .req_end_month       (req_end_month),
      .req_end_day         (req_end_day),
      .req_include_end_day (req_include_end_day),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_day_count       (rsp_day_count),
      .rsp_bad_start_date  (rsp_bad_start_date)
   );

endmodule

`default_nettype wire

FILE: src/ddd_checker.sv
// Port-level checks for the date difference block, bound to the top level.
`default_nettype none

module ddd_checker
   import ddd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic [YEAR_BITS-1:0]  req_start_year,
   input wire logic [MONTH_BITS-1:0] req_start_month,
   input wire logic [DAY_BITS-1:0]   req_start_day,
   input wire logic [YEAR_BITS-1:0]  req_end_year,
   input wire logic [MONTH_BITS-1:0] req_end_month,
   input wire logic [DAY_BITS-1:0]   req_end_day,
   input wire logic                  req_include_end_day,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [COUNT_BITS-1:0] rsp_day_count,
   input wire logic                  rsp_bad_start_date
);

   // stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_day_count) &&
                                 $stable(rsp_bad_start_date))
      else $error("stalled response changed");

   // a bad start date always reports a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_start_date |-> rsp_day_count == '0)
      else $error("bad start date with nonzero count");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // reduction and start check come before any response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##2 !rsp_valid)
      else $error("response too early");

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear handshake");

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (.*);

`default_nettype wire
